>>> rtl/core/hrlp_pkg.sv
// Package for the HTTP request-line parser: result types, event codes,
// method and version token tables. No dependencies.
`default_nettype none

package hrlp_pkg;

   typedef enum logic [1:0] {
      EV_PATH   = 2'd0,
      EV_ACCEPT = 2'd1,
      EV_REJECT = 2'd2
   } hrlp_event_type;

   typedef struct packed {
      hrlp_event_type event_res;
      logic [7:0]     path_char;
      logic [2:0]     method_code;
      logic [1:0]     version_code;
      logic [15:0]    consumed_count;
      logic [15:0]    line_length;
      logic           last_of_run;
   } hrlp_result_type;

   // up to two results caused by one byte; second only valid with first
   typedef struct packed {
      logic            first_valid;
      logic            second_valid;
      hrlp_result_type first;
      hrlp_result_type second;
   } hrlp_pair_type;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int METHOD_MAX_CHARS = 7;
   localparam int VERSION_CHARS    = 8;

   // method tokens, first character in the low byte, zero padded
   localparam logic [55:0] METHOD_NAMES [8] = '{
      56'h00000000544547,   // GET
      56'h00000000545550,   // PUT
      56'h00000044414548,   // HEAD
      56'h00000054534F50,   // POST
      56'h00004543415254,   // TRACE
      56'h004554454C4544,   // DELETE
      56'h534E4F4954504F,   // OPTIONS
      56'h5443454E4E4F43    // CONNECT
   };

   localparam logic [3:0] METHOD_LENS [8] = '{
      4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd7
   };

   // character idx of version string v: HTTP/1.1, HTTP/1.0, HTTP/0.9
   function automatic logic [7:0] version_char(input logic [1:0] v, input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h48;
         3'd1: c = 8'h54;
         3'd2: c = 8'h54;
         3'd3: c = 8'h50;
         3'd4: c = 8'h2F;
         3'd5: c = (v == 2'd2) ? 8'h30 : 8'h31;
         3'd6: c = 8'h2E;
         3'd7: begin
            case (v)
               2'd0:    c = 8'h31;
               2'd1:    c = 8'h30;
               default: c = 8'h39;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/hrlp_if.sv
// Valid/ready channel interfaces for the request-line parser:
// byte input channel and result channel. No dependencies.
`default_nettype none

interface hrlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface hrlp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic [7:0]  path_char;
   logic [2:0]  method_code;
   logic [1:0]  version_code;
   logic [15:0] consumed_count;
   logic [15:0] line_length;
   logic        last_of_run;

   modport source (output valid, output event_res, output path_char, output method_code,
                   output version_code, output consumed_count, output line_length,
                   output last_of_run, input ready);
   modport sink   (input valid, input event_res, input path_char, input method_code,
                   input version_code, input consumed_count, input line_length,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hrlp_parse.sv
// Parse state and per-byte next-state logic of the request-line parser.
// Depends on hrlp_pkg.
`default_nettype none

module hrlp_parse
   import hrlp_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [7:0]    data_byte,
   output hrlp_pair_type      results
);

   typedef enum logic [1:0] {
      PH_METHOD,
      PH_PATH,
      PH_VERSION,
      PH_TRAIL
   } phase_type;

   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

   phase_type             phase_ff,   phase_in;
   logic [55:0]           chars_ff,   chars_in;
   logic [3:0]            fcc_ff,     fcc_in;
   logic [2:0]            method_ff,  method_in;
   logic [2:0]            cand_ff,    cand_in;
   logic [1:0]            lec_ff,     lec_in;
   logic [1:0]            vfound_ff,  vfound_in;
   logic [COUNT_BITS-1:0] bc_ff,      bc_in;
   logic [COUNT_BITS-1:0] rlb_ff,     rlb_in;

   logic [15:0] bc_clip, rlb_clip;
   logic        hit;
   logic [2:0]  found;
   logic [1:0]  vsel;
   logic        term;
   logic        clr;
   logic        restart;
   hrlp_pair_type pair;

   generate
      if (COUNT_BITS > 16) begin : g_clip
         assign bc_clip  = (|bc_ff[COUNT_BITS-1:16])  ? 16'hFFFF : bc_ff[15:0];
         assign rlb_clip = (|rlb_ff[COUNT_BITS-1:16]) ? 16'hFFFF : rlb_ff[15:0];
      end else begin : g_ext
         assign bc_clip  = 16'(bc_ff);
         assign rlb_clip = 16'(rlb_ff);
      end
   endgenerate

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + CNT_ONE;
   endfunction

   function automatic hrlp_result_type mk_result(input hrlp_event_type ev,
                                                 input logic [7:0] pc,
                                                 input logic [2:0] mc,
                                                 input logic [1:0] vc,
                                                 input logic [15:0] cc,
                                                 input logic [15:0] ll);
      hrlp_result_type r;
      r.event_res      = ev;
      r.path_char      = pc;
      r.method_code    = mc;
      r.version_code   = vc;
      r.consumed_count = cc;
      r.line_length    = ll;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   // method token lookup on the characters gathered so far
   always_comb begin
      hit   = 1'b0;
      found = 3'd0;
      for (int m = 0; m < 8; m++) begin
         if (!hit && fcc_ff == METHOD_LENS[m] && chars_ff == METHOD_NAMES[m]) begin
            hit   = 1'b1;
            found = 3'(m);
         end
      end
   end

   // first version string still possible
   always_comb begin
      if (cand_ff[0]) begin
         vsel = 2'd0;
      end else if (cand_ff[1]) begin
         vsel = 2'd1;
      end else begin
         vsel = 2'd2;
      end
   end

   assign term = (data_byte == CHAR_NUL) || (data_byte == CHAR_CR) || (data_byte == CHAR_LF);

   always_comb begin
      phase_in  = phase_ff;
      chars_in  = chars_ff;
      fcc_in    = fcc_ff;
      method_in = method_ff;
      cand_in   = cand_ff;
      lec_in    = lec_ff;
      vfound_in = vfound_ff;
      bc_in     = bc_ff;
      rlb_in    = rlb_ff;
      clr       = 1'b0;
      restart   = 1'b0;
      pair.first_valid  = 1'b0;
      pair.second_valid = 1'b0;
      pair.first  = mk_result(EV_REJECT, 8'd0, 3'd0, 2'd0, 16'd0, 16'd0);
      pair.second = mk_result(EV_REJECT, 8'd0, 3'd0, 2'd0, 16'd0, 16'd0);

      case (phase_ff)
         PH_METHOD: begin
            if (data_byte == CHAR_NUL) begin
               clr = 1'b1;
               pair.first_valid = 1'b1;
            end else if (data_byte == CHAR_SPACE) begin
               if (hit) begin
                  method_in = found;
                  phase_in  = PH_PATH;
                  fcc_in    = 4'd0;
                  bc_in     = sat_inc(bc_ff);
                  rlb_in    = sat_inc(rlb_ff);
               end else begin
                  clr = 1'b1;
                  pair.first_valid = 1'b1;
               end
            end else if (fcc_ff >= 4'(METHOD_MAX_CHARS)) begin
               clr = 1'b1;
               pair.first_valid = 1'b1;
            end else begin
               for (int i = 0; i < METHOD_MAX_CHARS; i++) begin
                  if (fcc_ff == 4'(i)) begin
                     chars_in[8*i +: 8] = data_byte;
                  end
               end
               fcc_in = fcc_ff + 4'd1;
               bc_in  = sat_inc(bc_ff);
               rlb_in = sat_inc(rlb_ff);
            end
         end
         PH_PATH: begin
            if (data_byte == CHAR_NUL) begin
               clr = 1'b1;
               pair.first_valid = 1'b1;
            end else begin
               bc_in  = sat_inc(bc_ff);
               rlb_in = sat_inc(rlb_ff);
               if (data_byte == CHAR_SPACE) begin
                  phase_in = PH_VERSION;
                  fcc_in   = 4'd0;
               end else begin
                  pair.first_valid = 1'b1;
                  pair.first = mk_result(EV_PATH, data_byte, 3'd0, 2'd0, 16'd0, 16'd0);
               end
            end
         end
         PH_VERSION: begin
            if (fcc_ff >= 4'(VERSION_CHARS)) begin
               if (!term) begin
                  clr = 1'b1;
                  pair.first_valid = 1'b1;
               end else if (data_byte == CHAR_NUL) begin
                  clr = 1'b1;
                  pair.first_valid = 1'b1;
                  pair.first = mk_result(EV_ACCEPT, 8'd0, method_ff, vsel, bc_clip, rlb_clip);
               end else begin
                  vfound_in = vsel;
                  bc_in     = sat_inc(bc_ff);
                  lec_in    = 2'd1;
                  phase_in  = PH_TRAIL;
               end
            end else if (term) begin
               clr = 1'b1;
               pair.first_valid = 1'b1;
            end else begin
               for (int v = 0; v < 3; v++) begin
                  if (version_char(2'(v), fcc_ff[2:0]) != data_byte) begin
                     cand_in[v] = 1'b0;
                  end
               end
               if (cand_in == 3'd0) begin
                  clr = 1'b1;
                  pair.first_valid = 1'b1;
               end else begin
                  fcc_in = fcc_ff + 4'd1;
                  bc_in  = sat_inc(bc_ff);
                  rlb_in = sat_inc(rlb_ff);
               end
            end
         end
         PH_TRAIL: begin
            if (data_byte == CHAR_CR || data_byte == CHAR_LF) begin
               if (lec_ff >= 2'd2) begin
                  clr = 1'b1;
                  pair.first_valid = 1'b1;
               end else begin
                  lec_in = lec_ff + 2'd1;
                  bc_in  = sat_inc(bc_ff);
               end
            end else begin
               clr = 1'b1;
               pair.first_valid = 1'b1;
               pair.first = mk_result(EV_ACCEPT, 8'd0, method_ff, vfound_ff, bc_clip, rlb_clip);
               // non-zero accepting byte opens the next line; a space there rejects it
               if (data_byte == CHAR_SPACE) begin
                  pair.second_valid = 1'b1;
               end else if (data_byte != CHAR_NUL) begin
                  restart = 1'b1;
               end
            end
         end
         default: begin
            clr = 1'b1;
         end
      endcase

      if (clr) begin
         phase_in  = PH_METHOD;
         chars_in  = 56'd0;
         fcc_in    = 4'd0;
         method_in = 3'd0;
         cand_in   = 3'b111;
         lec_in    = 2'd0;
         vfound_in = 2'd0;
         bc_in     = '0;
         rlb_in    = '0;
         if (restart) begin
            chars_in = {48'd0, data_byte};
            fcc_in   = 4'd1;
            bc_in    = CNT_ONE;
            rlb_in   = CNT_ONE;
         end
      end

      if (pair.second_valid) begin
         pair.second.last_of_run = 1'b1;
      end else begin
         pair.first.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_METHOD;
         chars_ff  <= 56'd0;
         fcc_ff    <= 4'd0;
         method_ff <= 3'd0;
         cand_ff   <= 3'b111;
         lec_ff    <= 2'd0;
         vfound_ff <= 2'd0;
         bc_ff     <= '0;
         rlb_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         chars_ff  <= chars_in;
         fcc_ff    <= fcc_in;
         method_ff <= method_in;
         cand_ff   <= cand_in;
         lec_ff    <= lec_in;
         vfound_ff <= vfound_in;
         bc_ff     <= bc_in;
         rlb_ff    <= rlb_in;
      end
   end

   always_comb begin
      results = pair;
      results.first_valid  = pair.first_valid & step;
      results.second_valid = pair.second_valid & step;
   end

endmodule

`default_nettype wire

>>> rtl/core/hrlp_out_queue.sv
// Result queue of the request-line parser: takes up to two result words
// per cycle, hands out one. Depends on hrlp_pkg.
`default_nettype none

module hrlp_out_queue
   import hrlp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire hrlp_pair_type push,
   output logic               room,
   output logic               head_valid,
   output hrlp_result_type    head,
   input  wire logic          head_ready
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   hrlp_result_type entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] n_push;
   logic                pop;

   assign n_push     = CNT_BITS'(push.first_valid) + CNT_BITS'(push.second_valid);
   assign pop        = head_valid & head_ready;
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ff];
   // room for a full pair
   assign room       = (count_ff <= CNT_BITS'(QUEUE_DEPTH - 2));

   assign wr_in    = wr_ff + PTR_BITS'(n_push);
   assign rd_in    = rd_ff + PTR_BITS'(pop);
   assign count_in = count_ff + n_push - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_ff + PTR_BITS'(1)] <= push.second;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/http_request_line_parser.sv
// HTTP request-line parser, top level: parse stage plus result queue.
// Depends on hrlp_pkg, hrlp_if, hrlp_parse, hrlp_out_queue.
//
// Streams an HTTP/1.x or HTTP/0.9 request line one byte per word on req_if
// and emits path-byte, line-accepted and line-rejected words on rsp_if. One
// byte is taken per clock cycle while the queue has room; its results enter
// a four-word output queue, and if the queue held no earlier words the first
// of them is offered on rsp_if the cycle after the byte is taken. Most bytes
// cause zero or one result; a byte that both accepts a line and rejects the
// next (a space after the trailing CR/LF) causes two, which leave the queue
// one after the other. req_if.ready is high whenever the queue has room for
// two words, so with rsp_if.ready held high the input never stalls. The byte
// counters are COUNT_BITS wide and saturate; reported counts clip at 65535.
`default_nettype none

module http_request_line_parser
   import hrlp_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hrlp_req_if.sink    req_if,
   hrlp_rsp_if.source  rsp_if
);

   logic            room;
   logic            step;
   hrlp_pair_type   pair;
   hrlp_result_type head;

   assign req_if.ready = room;
   assign step         = req_if.valid & room;

   hrlp_parse #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (req_if.data_byte),
      .results   (pair)
   );

   hrlp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (pair),
      .room       (room),
      .head_valid (rsp_if.valid),
      .head       (head),
      .head_ready (rsp_if.ready)
   );

   assign rsp_if.event_res      = head.event_res;
   assign rsp_if.path_char      = head.path_char;
   assign rsp_if.method_code    = head.method_code;
   assign rsp_if.version_code   = head.version_code;
   assign rsp_if.consumed_count = head.consumed_count;
   assign rsp_if.line_length    = head.line_length;
   assign rsp_if.last_of_run    = head.last_of_run;

endmodule

`default_nettype wire
